@@ design/tlv_message_parser_defines.svh @@
// assertion macros for the tlv message parser
`ifndef TLV_MESSAGE_PARSER_DEFINES_SVH
`define TLV_MESSAGE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define TLVMP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TLVMP_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define TLVMP_ASSERT(lbl, clk, rstn, prop, msg)
`define TLVMP_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ design/tlvmp_pkg.sv @@
// shared types and constants for the tlv message parser
`default_nettype none
package tlvmp_pkg;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_NUMBER_CODE      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STRING_CODE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COMMAND_END_CODE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ANSWER_END_CODE  = 2'd3;

    localparam logic [7:0] NUMBER_CODE_RST      = 8'd41;
    localparam logic [7:0] STRING_CODE_RST      = 8'd40;
    localparam logic [7:0] COMMAND_END_CODE_RST = 8'd8;
    localparam logic [7:0] ANSWER_END_CODE_RST  = 8'd27;

    localparam logic [2:0] PH_ID    = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_NUM   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_CHARS = 3'd4;

    localparam logic [2:0] KIND_ID    = 3'd0;
    localparam logic [2:0] KIND_NUM   = 3'd1;
    localparam logic [2:0] KIND_LEN   = 3'd2;
    localparam logic [2:0] KIND_CHAR  = 3'd3;
    localparam logic [2:0] KIND_OTHER = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;

    typedef struct packed {
        logic [7:0] number_code;
        logic [7:0] string_code;
        logic [7:0] command_end_code;
        logic [7:0] answer_end_code;
    } cfg_t;

    typedef struct packed {
        logic               emit;
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic               last;
    } token_t;

endpackage
`default_nettype wire

@@ design/tlv_message_parser.sv @@
// tlv message parser: one byte in per cycle, tokens out as they complete
// a token appears on the m_ side in the cycle after the byte that completes it is accepted
// input rate: one byte per cycle; s_ready drops only while a token waits unaccepted
// bytes opening a 32-bit field, and all but the last byte inside one, produce no token
// reset (aresetn, synchronous, active low): parser expects a command id,
// codes return to 41, 40, 8, 27 and the result register empties
`default_nettype none
`include "tlv_message_parser_defines.svh"
module tlv_message_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [tlvmp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [tlvmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_rx_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [2:0]                            m_token_kind,
    output logic signed [31:0]                    m_token_value,
    output logic                                  m_last
);

    tlvmp_pkg::cfg_t   cfg;
    tlvmp_pkg::token_t tok;
    logic [2:0]        phase;
    logic              in_accept;

    assign in_accept = s_valid && s_ready;

    tlvmp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tlvmp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .rx_byte   (s_rx_byte),
        .tok       (tok),
        .phase     (phase)
    );

    tlvmp_out_reg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .tok           (tok),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_token_value (m_token_value),
        .m_last        (m_last)
    );

    `TLVMP_ASSERT(a_end_back_to_id, aclk, aresetn, (in_accept && tok.emit && tok.last) |=> (phase == tlvmp_pkg::PH_ID), "end token did not return parser to command id")
    `TLVMP_ASSERT(a_id_token, aclk, aresetn, (in_accept && (phase == tlvmp_pkg::PH_ID)) |-> (tok.emit && (tok.kind == tlvmp_pkg::KIND_ID)), "command id byte gave no id token")
    `TLVMP_ASSERT(a_last_is_end, aclk, aresetn, m_valid |-> (m_last == (m_token_kind == tlvmp_pkg::KIND_END)), "last flag and end kind disagree")
    `TLVMP_ASSERT_NEVER(a_char_range, aclk, aresetn, m_valid && (m_token_kind == tlvmp_pkg::KIND_CHAR) && (m_token_value[31:8] != 24'd0), "string character token out of byte range")

endmodule
`default_nettype wire

@@ design/tlvmp_cfg_regs.sv @@
// configuration registers with their reset codes
`default_nettype none
module tlvmp_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [tlvmp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [tlvmp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output tlvmp_pkg::cfg_t                          cfg
);

    tlvmp_pkg::cfg_t cfg_reg;
    tlvmp_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                tlvmp_pkg::REG_NUMBER_CODE:      cfg_next.number_code      = cfg_wdata;
                tlvmp_pkg::REG_STRING_CODE:      cfg_next.string_code      = cfg_wdata;
                tlvmp_pkg::REG_COMMAND_END_CODE: cfg_next.command_end_code = cfg_wdata;
                tlvmp_pkg::REG_ANSWER_END_CODE:  cfg_next.answer_end_code  = cfg_wdata;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.number_code      <= tlvmp_pkg::NUMBER_CODE_RST;
            cfg_reg.string_code      <= tlvmp_pkg::STRING_CODE_RST;
            cfg_reg.command_end_code <= tlvmp_pkg::COMMAND_END_CODE_RST;
            cfg_reg.answer_end_code  <= tlvmp_pkg::ANSWER_END_CODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ design/tlvmp_parse.sv @@
// parser state and per-byte token decode
`default_nettype none
module tlvmp_parse (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire tlvmp_pkg::cfg_t cfg,
    input  wire logic       in_accept,
    input  wire logic [7:0] rx_byte,
    output tlvmp_pkg::token_t tok,
    output logic [2:0]      phase
);

    logic [2:0]  phase_reg,      phase_next;
    logic [1:0]  byte_count_reg, byte_count_next;
    logic [31:0] acc_reg,        acc_next;
    logic [30:0] chars_left_reg, chars_left_next;

    logic [31:0] acc_shift;
    logic [30:0] chars_dec;
    logic        is_end;

    assign acc_shift = {acc_reg[23:0], rx_byte};
    assign chars_dec = (chars_left_reg != '0) ? chars_left_reg - 31'd1 : chars_left_reg;
    assign is_end    = (rx_byte == 8'd0) || (rx_byte == cfg.answer_end_code)
                    || (rx_byte == cfg.command_end_code);

    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        acc_next        = acc_reg;
        chars_left_next = chars_left_reg;
        tok             = '0;
        if (in_accept) begin
            case (phase_reg)
                tlvmp_pkg::PH_ID: begin
                    phase_next = tlvmp_pkg::PH_TYPE;
                    tok.emit   = 1'b1;
                    tok.kind   = tlvmp_pkg::KIND_ID;
                    tok.value  = {24'd0, rx_byte};
                end
                tlvmp_pkg::PH_TYPE: begin
                    if (is_end) begin
                        phase_next = tlvmp_pkg::PH_ID;
                        tok.emit   = 1'b1;
                        tok.kind   = tlvmp_pkg::KIND_END;
                        tok.value  = {24'd0, rx_byte};
                        tok.last   = 1'b1;
                    end else if (rx_byte == cfg.number_code) begin
                        phase_next      = tlvmp_pkg::PH_NUM;
                        byte_count_next = 2'd0;
                        acc_next        = '0;
                    end else if (rx_byte == cfg.string_code) begin
                        phase_next      = tlvmp_pkg::PH_LEN;
                        byte_count_next = 2'd0;
                        acc_next        = '0;
                    end else begin
                        tok.emit  = 1'b1;
                        tok.kind  = tlvmp_pkg::KIND_OTHER;
                        tok.value = {24'd0, rx_byte};
                    end
                end
                tlvmp_pkg::PH_NUM, tlvmp_pkg::PH_LEN: begin
                    acc_next = acc_shift;
                    if (byte_count_reg != 2'd3) begin
                        byte_count_next = byte_count_reg + 2'd1;
                    end else begin
                        byte_count_next = 2'd0;
                        tok.emit        = 1'b1;
                        tok.value       = acc_shift;
                        if (phase_reg == tlvmp_pkg::PH_NUM) begin
                            phase_next = tlvmp_pkg::PH_TYPE;
                            tok.kind   = tlvmp_pkg::KIND_NUM;
                        end else begin
                            tok.kind = tlvmp_pkg::KIND_LEN;
                            if ((acc_shift == '0) || acc_shift[31]) begin
                                phase_next      = tlvmp_pkg::PH_TYPE;
                                chars_left_next = '0;
                            end else begin
                                phase_next      = tlvmp_pkg::PH_CHARS;
                                chars_left_next = acc_shift[30:0];
                            end
                        end
                    end
                end
                tlvmp_pkg::PH_CHARS: begin
                    chars_left_next = chars_dec;
                    if (chars_dec == '0) begin
                        phase_next = tlvmp_pkg::PH_TYPE;
                    end
                    tok.emit  = 1'b1;
                    tok.kind  = tlvmp_pkg::KIND_CHAR;
                    tok.value = {24'd0, rx_byte};
                end
                default: begin
                    phase_next      = tlvmp_pkg::PH_ID;
                    byte_count_next = 2'd0;
                    acc_next        = '0;
                    chars_left_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= tlvmp_pkg::PH_ID;
            byte_count_reg <= 2'd0;
            acc_reg        <= '0;
            chars_left_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            acc_reg        <= acc_next;
            chars_left_reg <= chars_left_next;
        end
    end

    assign phase = phase_reg;

endmodule
`default_nettype wire

@@ design/tlvmp_out_reg.sv @@
// result register with valid/ready handshake
`default_nettype none
module tlvmp_out_reg (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_accept,
    input  wire tlvmp_pkg::token_t tok,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_token_kind,
    output logic signed [31:0] m_token_value,
    output logic              m_last
);

    logic               valid_reg, valid_next;
    logic [2:0]         kind_reg;
    logic signed [31:0] value_reg;
    logic               last_reg;
    logic               load;

    assign load = in_accept && tok.emit;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= tok.kind;
            value_reg <= tok.value;
            last_reg  <= tok.last;
        end
    end

    assign s_ready       = !valid_reg || m_ready;
    assign m_valid       = valid_reg;
    assign m_token_kind  = kind_reg;
    assign m_token_value = value_reg;
    assign m_last        = last_reg;

endmodule
`default_nettype wire
